[design/assert_macros.svh]
// assertion macros shared by the rc channel frame receiver rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define RCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/rcfr_pkg.sv]
// shared constants, types and the crc step for the rc channel frame receiver
// no dependencies
`default_nettype none

package rcfr_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned PayloadBytes = 22;
  localparam int unsigned PayloadW     = PayloadBytes * ByteW;
  localparam int unsigned ChanW        = 11;
  localparam int unsigned NumChan      = 16;
  localparam int unsigned ChanIdxW     = $clog2(NumChan);
  localparam int unsigned BodyCntW     = 5;

  localparam logic [ByteW-1:0]    FrameLength = 8'd24;
  localparam logic [BodyCntW-1:0] BodyBytes   = 5'd23;
  localparam logic [ByteW-1:0]    CrcPoly     = 8'hD5;
  localparam logic [ByteW-1:0]    SyncReset   = 8'hC8;
  localparam logic [ChanIdxW-1:0] LastChan    = ChanIdxW'(NumChan - 1);

  // one completed, crc-clean frame handed to the emitter
  typedef struct packed {
    logic                load;
    logic [PayloadW-1:0] payload;
  } frame_t;

  // crc-8, msb first, one byte
  function automatic logic [ByteW-1:0] crc8_step(logic [ByteW-1:0] crc,
                                                 logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/rcfr_frame_parser.sv]
// sync hunt, length check, crc accumulation and payload capture
// depends on rcfr_pkg
`default_nettype none

module rcfr_frame_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [rcfr_pkg::ByteW-1:0] cfg_wdata_i,
  input  wire logic                      rx_valid_i,
  output logic                           rx_ready_o,
  input  wire logic [rcfr_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                      emit_busy_i,
  output rcfr_pkg::frame_t               frame_o
);
  import rcfr_pkg::*;

  localparam logic [1:0] PhSync = 2'd0;
  localparam logic [1:0] PhLen  = 2'd1;
  localparam logic [1:0] PhBody = 2'd2;

  logic [ByteW-1:0]    sync_q;
  logic [1:0]          phase_q, phase_d;
  logic [BodyCntW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]    crc_q, crc_d;
  logic [PayloadW-1:0] pay_q, pay_d;
  logic                rx_fire;
  logic                at_check;
  logic                load;

  assign at_check   = (phase_q == PhBody) && (cnt_q == BodyBytes);
  // hold the check byte back until the emitter has room for a new frame
  assign rx_ready_o = !(at_check && emit_busy_i);
  assign rx_fire    = rx_valid_i && rx_ready_o;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    pay_d   = pay_q;
    load    = 1'b0;
    case (phase_q)
      PhLen: begin
        if (rx_byte_i == FrameLength) begin
          phase_d = PhBody;
          cnt_d   = '0;
          crc_d   = '0;
        end else if (rx_byte_i != sync_q) begin
          phase_d = PhSync;
        end
      end
      PhBody: begin
        if (cnt_q < BodyBytes) begin
          // first body byte is the type, not stored
          if (cnt_q != '0) begin
            pay_d = {rx_byte_i, pay_q[PayloadW-1:ByteW]};
          end
          crc_d = crc8_step(crc_q, rx_byte_i);
          cnt_d = cnt_q + BodyCntW'(1);
        end else begin
          phase_d = PhSync;
          cnt_d   = '0;
          load    = (crc_q == rx_byte_i);
        end
      end
      default: begin
        phase_d = (rx_byte_i == sync_q) ? PhLen : PhSync;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= SyncReset;
      phase_q <= PhSync;
      cnt_q   <= '0;
      crc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
      if (rx_fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        crc_q   <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      pay_q <= pay_d;
    end
  end

  assign frame_o.load    = rx_fire && load;
  assign frame_o.payload = pay_q;

endmodule

`default_nettype wire

[design/rcfr_channel_emitter.sv]
// holds one clean frame and sends its sixteen 11-bit channels, one per beat
// depends on rcfr_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module rcfr_channel_emitter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rcfr_pkg::frame_t             frame_i,
  output logic                              busy_o,
  output logic                              ch_valid_o,
  input  wire logic                         ch_ready_i,
  output logic [rcfr_pkg::ChanIdxW-1:0]     channel_index_o,
  output logic [rcfr_pkg::ChanW-1:0]        channel_value_o,
  output logic                              last_channel_o
);
  import rcfr_pkg::*;

  logic                busy_q;
  logic [ChanIdxW-1:0] idx_q;
  logic [PayloadW-1:0] buf_q;
  logic                ch_fire;

  assign ch_fire = busy_q && ch_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (frame_i.load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (ch_fire) begin
      busy_q <= (idx_q != LastChan);
      idx_q  <= idx_q + ChanIdxW'(1);
    end
  end

  // channels are little-endian, lowest channel at the bottom
  always_ff @(posedge clk_i) begin
    if (frame_i.load) begin
      buf_q <= frame_i.payload;
    end else if (ch_fire) begin
      buf_q <= {ChanW'(0), buf_q[PayloadW-1:ChanW]};
    end
  end

  assign busy_o          = busy_q;
  assign ch_valid_o      = busy_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = buf_q[ChanW-1:0];
  assign last_channel_o  = (idx_q == LastChan);

  `RCFR_ASSERT(a_no_load_while_busy, frame_i.load |-> !busy_q, "frame loaded over pending channels")
  `RCFR_ASSERT(a_load_starts_at_zero, frame_i.load |=> (busy_q && idx_q == '0), "frame did not start at channel 0")
  `RCFR_ASSERT(a_last_ends_frame, (ch_fire && last_channel_o) |=> !busy_q, "emitter busy after last channel")

endmodule

`default_nettype wire

[design/rc_channel_frame_receiver_core.sv]
// top level of the rc channel frame receiver: frame parser plus channel emitter
// depends on rcfr_pkg, rcfr_frame_parser and rcfr_channel_emitter
//
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_byte_i) takes one serial byte per beat.
//   The parser hunts for the sync address then a length byte of 24, collects the
//   type byte and 22 payload bytes while running crc-8 (poly 0xd5), and checks
//   the final byte. A bad frame is dropped with no output.
//   Output channel (ch_valid_o/ch_ready_i) gives sixteen beats per clean frame:
//   channel_index_o, channel_value_o and last_channel_o on channel 15.
//   Latency: the first channel is valid the cycle after the check byte is taken,
//   then one channel per cycle while ch_ready_i is high.
//   Throughput: one byte per cycle; rx_ready_o only drops for a check byte that
//   arrives while the previous frame's channels are still being drained, so a
//   stalled receiver back-pressures the input at that point only.
//   cfg_we_i/cfg_wdata_i write the sync address register (0xc8 after reset).
//   Reset returns the hunt to the sync wait and empties the output.
`default_nettype none

module rc_channel_frame_receiver_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [rcfr_pkg::ByteW-1:0] cfg_wdata_i,
  input  wire logic                     rx_valid_i,
  output logic                          rx_ready_o,
  input  wire logic [rcfr_pkg::ByteW-1:0] rx_byte_i,
  output logic                          ch_valid_o,
  input  wire logic                     ch_ready_i,
  output logic [rcfr_pkg::ChanIdxW-1:0] channel_index_o,
  output logic [rcfr_pkg::ChanW-1:0]    channel_value_o,
  output logic                          last_channel_o
);
  import rcfr_pkg::*;

  frame_t frame;
  logic   emit_busy;

  rcfr_frame_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .emit_busy_i (emit_busy),
    .frame_o     (frame)
  );

  rcfr_channel_emitter u_emitter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_i         (frame),
    .busy_o          (emit_busy),
    .ch_valid_o      (ch_valid_o),
    .ch_ready_i      (ch_ready_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

`default_nettype wire
